### rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
package skt_pkg;

  localparam int unsigned DEPTH_DEF         = 16;
  localparam int unsigned PAYLOAD_WIDTH_DEF = 32;
  localparam int unsigned KEY_W             = 16;
  localparam int unsigned PORT_PAYLOAD_W    = 32;
  localparam int unsigned COUNT_OUT_W       = 5;
  localparam int unsigned POS_W             = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY_POS = 2'd3
  } status_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                    insert_en;
    logic                    remove_en;
    logic signed [KEY_W-1:0] key;
  } skt_cmd_t;

  // Per-cell compare flags returned to the controller and the neighbor.
  typedef struct packed {
    logic at;   // cell sits at or after the key's slot
    logic hit;  // cell is the slot and holds an equal key
  } skt_flags_t;

endpackage

### rtl/skt_if.sv
// Handshake channel interfaces for commands and results.
interface skt_in_if import skt_pkg::*; ;
  logic                             valid;
  logic                             ready;
  opcode_t                          opcode;
  logic signed [KEY_W-1:0]          key_year;
  logic        [PORT_PAYLOAD_W-1:0] payload_in;
  logic        [POS_W-1:0]          position;

  modport source (output valid, opcode, key_year, payload_in, position, input ready);
  modport sink   (input valid, opcode, key_year, payload_in, position, output ready);
endinterface

interface skt_out_if import skt_pkg::*; ;
  logic                             valid;
  logic                             ready;
  status_t                          status;
  logic signed [KEY_W-1:0]          key_out;
  logic        [PORT_PAYLOAD_W-1:0] payload_out;
  logic        [COUNT_OUT_W-1:0]    entry_count;

  modport source (output valid, status, key_out, payload_out, entry_count, input ready);
  modport sink   (input valid, status, key_out, payload_out, entry_count, output ready);
endinterface

### rtl/skt_cell.sv
// One table cell: holds an entry, compares it with the command key, shifts.
module skt_cell import skt_pkg::*; #(
  parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic                     clk,
  input  skt_cmd_t                 cmd,
  input  logic [PAYLOAD_WIDTH-1:0] new_payload,
  input  logic                     occ,          // cell index below entry count
  input  logic                     left_at,
  input  logic signed [KEY_W-1:0]  left_key,
  input  logic [PAYLOAD_WIDTH-1:0] left_payload,
  input  logic signed [KEY_W-1:0]  right_key,
  input  logic [PAYLOAD_WIDTH-1:0] right_payload,
  output skt_flags_t               flags,
  output logic signed [KEY_W-1:0]  key_q,
  output logic [PAYLOAD_WIDTH-1:0] payload_q
);

  logic signed [KEY_W-1:0]  key_r, key_nxt;
  logic [PAYLOAD_WIDTH-1:0] payload_r, payload_nxt;
  logic                     first;

  always_comb begin
    flags.at  = !occ || (key_r >= cmd.key);
    first     = flags.at && !left_at;
    flags.hit = occ && first && (key_r == cmd.key);
  end

  always_comb begin
    key_nxt     = key_r;
    payload_nxt = payload_r;
    if (cmd.insert_en && first) begin
      key_nxt     = cmd.key;
      payload_nxt = new_payload;
    end else if (cmd.insert_en && flags.at) begin
      key_nxt     = left_key;
      payload_nxt = left_payload;
    end else if (cmd.remove_en && flags.at) begin
      key_nxt     = right_key;
      payload_nxt = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    payload_r <= payload_nxt;
  end

  assign key_q     = key_r;
  assign payload_q = payload_r;

endmodule

### rtl/sorted_key_table_unit.sv
// Top level of the sorted key table: a row of shifting cells plus control.
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+------------------------------------------
//  in_chan | in  | valid/ready   | opcode, key_year, payload_in, position
//  out_chan| out | valid/ready   | status, key_out, payload_out, entry_count
//
// One command per cycle while out_chan is not stalled: every cell compares its
// key with the command key in parallel and shifts by one in the same cycle, so
// the result word is registered on acceptance and valid in the cycle after.
// Reset (rst_n low, synchronous) empties the table and drops any result;
// cell contents are not cleared.
// A result waiting on out_chan does not block input while out_chan.ready is
// high; with out_chan stalled and a result held, in_chan.ready is low.
module sorted_key_table_unit import skt_pkg::*; #(
  parameter int unsigned DEPTH         = DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  skt_in_if.sink     in_chan,
  skt_out_if.source  out_chan
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  status_t       status_r;
  logic signed [KEY_W-1:0]          key_out_r;
  logic        [PORT_PAYLOAD_W-1:0] payload_out_r;
  logic        [COUNT_OUT_W-1:0]    entry_count_r;

  skt_cmd_t                 cmd;
  skt_flags_t               flags   [DEPTH];
  logic signed [KEY_W-1:0]  cell_key[DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_pay[DEPTH];
  logic [DEPTH-1:0]         hit_vec;
  logic [PAYLOAD_WIDTH-1:0] new_payload;

  logic    accept, full, found, pos_ok;
  status_t status_nxt;
  logic signed [KEY_W-1:0]  rd_key;
  logic [PAYLOAD_WIDTH-1:0] rd_pay;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign full          = (count_r == CW'(DEPTH));
  assign found         = |hit_vec;
  assign new_payload   = PAYLOAD_WIDTH'(in_chan.payload_in);

  always_comb begin
    cmd.key       = in_chan.key_year;
    cmd.insert_en = accept && (in_chan.opcode == OP_INSERT) && !full;
    cmd.remove_en = accept && (in_chan.opcode == OP_REMOVE) && found;
  end

  // cell row; the ends see their own key and payload as the missing neighbor's, and cell 0 sees left_at low
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned L = (i == 0) ? 0 : i - 1;
    localparam int unsigned R = (i == DEPTH - 1) ? i : i + 1;

    skt_cell #(.PAYLOAD_WIDTH(PAYLOAD_WIDTH)) u_cell (
      .clk           (clk),
      .cmd           (cmd),
      .new_payload   (new_payload),
      .occ           (CW'(i) < count_r),
      .left_at       ((i == 0) ? 1'b0 : flags[L].at),
      .left_key      (cell_key[L]),
      .left_payload  (cell_pay[L]),
      .right_key     (cell_key[R]),
      .right_payload (cell_pay[R]),
      .flags         (flags[i]),
      .key_q         (cell_key[i]),
      .payload_q     (cell_pay[i])
    );

    assign hit_vec[i] = flags[i].hit;
  end

  // read port: select the cell named by position
  always_comb begin
    rd_key = '0;
    rd_pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == int'(in_chan.position)) begin
        rd_key = cell_key[i];
        rd_pay = cell_pay[i];
      end
    end
  end

  assign pos_ok = int'(in_chan.position) < int'(count_r);

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    case (in_chan.opcode)
      OP_INSERT: begin
        if (full) status_nxt = ST_FULL;
        else      count_nxt  = count_r + CW'(1);
      end
      OP_REMOVE: begin
        if (found) count_nxt  = count_r - CW'(1);
        else       status_nxt = ST_NOT_FOUND;
      end
      OP_READ: begin
        if (!pos_ok) status_nxt = ST_EMPTY_POS;
      end
      OP_CLEAR: count_nxt = '0;
      default:  count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word; key and payload only carry data for a good read
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      entry_count_r <= COUNT_OUT_W'(count_nxt);
      if (in_chan.opcode == OP_READ && pos_ok) begin
        key_out_r     <= rd_key;
        payload_out_r <= PORT_PAYLOAD_W'(rd_pay);
      end else begin
        key_out_r     <= '0;
        payload_out_r <= '0;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.key_out     = key_out_r;
  assign out_chan.payload_out = payload_out_r;
  assign out_chan.entry_count = entry_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one cell claims the remove slot");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.opcode == OP_CLEAR |=> count_r == '0 && out_valid_r)
    else $error("clear did not empty the table");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.opcode == OP_INSERT && full |=> $stable(count_r))
    else $error("insert on a full table changed the count");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !in_chan.ready)
    else $error("input taken while a result is stalled");
`endif

endmodule
